// File: hw/rtl/plist_pkg.sv
// ----------------------------------------------------------------------------
// plist_pkg
// Shared types and constants of the positional list engine.
// ----------------------------------------------------------------------------
package plist_pkg;

  localparam int CAPACITY   = 16;
  localparam int DATA_W     = 32;
  localparam int OP_W       = 3;
  localparam int POS_W      = 5;
  localparam int STATUS_W   = 3;
  localparam int COUNT_W    = 5;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [OP_W-1:0] {
    OP_INS_HEAD = 3'd0,
    OP_INS_TAIL = 3'd1,
    OP_INS_AT   = 3'd2,
    OP_RM_HEAD  = 3'd3,
    OP_RM_TAIL  = 3'd4,
    OP_RM_AT    = 3'd5,
    OP_RM_VAL   = 3'd6,
    OP_SEARCH   = 3'd7
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_OK       = 3'd0,
    STS_BADPOS   = 3'd1,
    STS_EMPTY    = 3'd2,
    STS_NOTFOUND = 3'd3,
    STS_FULL     = 3'd4
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_MOVE   = 5'b00100,
    S_PUT    = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

endpackage

// File: hw/rtl/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit values held in one RAM, with insert,
// remove and search requests and one status word returned per request.
// ----------------------------------------------------------------------------
//  channel  direction  tdata fields (lowest bit up)
//  s_axis   in         op[2:0], position[7:3], value[39:8]
//  m_axis   out        status[2:0], found[3], count[8:4], zero pad[15:9]
//
// A request is accepted in the idle state; the RAM then moves or compares
// one entry per cycle through its single read port.
// Error cases and tail removal skip the move and scan states.
// Reset clears entry count and control state; RAM contents are not cleared.
// A new word is accepted while the previous result still waits in the output
// register; the engine stalls in its final state if that register is full.
// ----------------------------------------------------------------------------
module positional_list_engine #(
  parameter int Capacity = plist_pkg::CAPACITY
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // op[2:0], position[7:3], value[39:8]
  input  logic [plist_pkg::IN_TDATA_W-1:0]    s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // status[2:0], found[3], count[8:4], zero pad[15:9]
  output logic [plist_pkg::OUT_TDATA_W-1:0]   m_axis_tdata_o
);

  localparam int AW = $clog2(Capacity);
  localparam int CW = $clog2(Capacity + 1);
  localparam int XW = ((CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W) + 1;
  localparam int DW = plist_pkg::DATA_W;

  plist_pkg::state_e  state_q, state_d;
  plist_pkg::op_e     op_q, op_d;
  plist_pkg::status_e status_q, status_d;
  logic [DW-1:0]      val_q, val_d;
  logic [CW-1:0]      len_q, len_d;
  logic               found_q, found_d;
  logic [AW-1:0]      put_idx_q, put_idx_d;
  logic [AW-1:0]      mv_src_q, mv_src_d;
  logic [CW-1:0]      mv_left_q, mv_left_d;
  logic               mv_up_q, mv_up_d;
  logic               wb_valid_q, wb_valid_d;
  logic [AW-1:0]      wb_addr_q, wb_addr_d;
  logic [CW-1:0]      sc_rd_q, sc_rd_d;
  logic               sc_chk_q, sc_chk_d;
  logic [CW-1:0]      sc_idx_q, sc_idx_d;

  logic                                  m_valid_q, m_valid_d;
  logic [plist_pkg::STATUS_W-1:0]        m_status_q, m_status_d;
  logic                                  m_found_q, m_found_d;
  logic [plist_pkg::COUNT_W-1:0]         m_count_q, m_count_d;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  plist_pkg::op_e               in_op;
  logic [plist_pkg::POS_W-1:0]  in_pos;
  logic [DW-1:0]                in_val;
  logic                         in_fire;
  logic [XW-1:0]                len_x;
  logic [XW-1:0]                pos_x;
  logic [CW-1:0]                pos_m1;
  logic [CW-1:0]                ins_k;
  logic [CW-1:0]                rm_idx;
  logic [CW-1:0]                sc_moves;
  logic [XW-1:0]                len_ext;
  logic                         is_insert;

  plist_ram #(
    .Width (DW),
    .Depth (Capacity)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_op   = plist_pkg::op_e'(s_axis_tdata_i[2:0]);
  assign in_pos  = s_axis_tdata_i[7:3];
  assign in_val  = s_axis_tdata_i[39:8];
  assign s_axis_tready_o = (state_q == plist_pkg::S_IDLE);
  assign in_fire = s_axis_tvalid_i && s_axis_tready_o;

  assign len_x    = XW'(len_q);
  assign pos_x    = XW'(in_pos);
  assign pos_m1   = CW'(pos_x - XW'(1));
  assign ins_k    = (in_op == plist_pkg::OP_INS_HEAD) ? '0 :
                    (in_op == plist_pkg::OP_INS_TAIL) ? len_q : pos_m1;
  assign rm_idx   = (in_op == plist_pkg::OP_RM_HEAD) ? '0 : pos_m1;
  assign sc_moves = len_q - CW'(1) - sc_idx_q;
  assign len_ext  = XW'(len_q);
  assign is_insert = (op_q == plist_pkg::OP_INS_HEAD) || (op_q == plist_pkg::OP_INS_TAIL) ||
                     (op_q == plist_pkg::OP_INS_AT);

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    status_d   = status_q;
    val_d      = val_q;
    len_d      = len_q;
    found_d    = found_q;
    put_idx_d  = put_idx_q;
    mv_src_d   = mv_src_q;
    mv_left_d  = mv_left_q;
    mv_up_d    = mv_up_q;
    wb_valid_d = 1'b0;
    wb_addr_d  = wb_addr_q;
    sc_rd_d    = sc_rd_q;
    sc_chk_d   = 1'b0;
    sc_idx_d   = sc_idx_q;
    m_valid_d  = m_valid_q;
    m_status_d = m_status_q;
    m_found_d  = m_found_q;
    m_count_d  = m_count_q;
    ram_we     = 1'b0;
    ram_waddr  = wb_addr_q;
    ram_wdata  = ram_rdata;
    ram_raddr  = mv_src_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      plist_pkg::S_IDLE: begin
        if (in_fire) begin
          op_d     = in_op;
          val_d    = in_val;
          status_d = plist_pkg::STS_OK;
          found_d  = 1'b0;
          state_d  = plist_pkg::S_FINISH;
          case (in_op)
            plist_pkg::OP_INS_HEAD, plist_pkg::OP_INS_TAIL, plist_pkg::OP_INS_AT: begin
              if ((in_op == plist_pkg::OP_INS_AT) &&
                  ((pos_x == '0) || (pos_x > len_x + XW'(1)))) begin
                status_d = plist_pkg::STS_BADPOS;
              end else if (len_x >= XW'(Capacity)) begin
                status_d = plist_pkg::STS_FULL;
              end else begin
                put_idx_d = AW'(ins_k);
                mv_left_d = len_q - ins_k;
                mv_src_d  = AW'(len_q - CW'(1));
                mv_up_d   = 1'b0;
                state_d   = (len_q == ins_k) ? plist_pkg::S_PUT : plist_pkg::S_MOVE;
              end
            end
            plist_pkg::OP_RM_HEAD, plist_pkg::OP_RM_TAIL, plist_pkg::OP_RM_AT: begin
              if (len_q == '0) begin
                status_d = plist_pkg::STS_EMPTY;
              end else if ((in_op == plist_pkg::OP_RM_AT) &&
                           ((pos_x == '0) || (pos_x > len_x))) begin
                status_d = plist_pkg::STS_BADPOS;
              end else begin
                len_d = len_q - CW'(1);
                if (in_op != plist_pkg::OP_RM_TAIL) begin
                  mv_left_d = len_q - CW'(1) - rm_idx;
                  mv_src_d  = AW'(rm_idx + CW'(1));
                  mv_up_d   = 1'b1;
                  if (len_q - CW'(1) != rm_idx) begin
                    state_d = plist_pkg::S_MOVE;
                  end
                end
              end
            end
            default: begin
              if (len_q == '0) begin
                status_d = plist_pkg::STS_NOTFOUND;
              end else begin
                sc_rd_d = '0;
                state_d = plist_pkg::S_SCAN;
              end
            end
          endcase
        end
      end

      plist_pkg::S_SCAN: begin
        ram_raddr = AW'(sc_rd_q);
        if (sc_rd_q < len_q) begin
          sc_chk_d = 1'b1;
          sc_idx_d = sc_rd_q;
          sc_rd_d  = sc_rd_q + CW'(1);
        end
        if (sc_chk_q && (ram_rdata == val_q)) begin
          found_d  = 1'b1;
          sc_chk_d = 1'b0;
          state_d  = plist_pkg::S_FINISH;
          if (op_q == plist_pkg::OP_RM_VAL) begin
            len_d     = len_q - CW'(1);
            mv_left_d = sc_moves;
            mv_src_d  = AW'(sc_idx_q + CW'(1));
            mv_up_d   = 1'b1;
            if (sc_moves != '0) begin
              state_d = plist_pkg::S_MOVE;
            end
          end
        end else if (sc_chk_q && (sc_idx_q == len_q - CW'(1))) begin
          sc_chk_d = 1'b0;
          status_d = plist_pkg::STS_NOTFOUND;
          state_d  = plist_pkg::S_FINISH;
        end
      end

      plist_pkg::S_MOVE: begin
        ram_raddr = mv_src_q;
        if (wb_valid_q) begin
          ram_we    = 1'b1;
          ram_waddr = wb_addr_q;
          ram_wdata = ram_rdata;
        end
        if (mv_left_q != '0) begin
          wb_valid_d = 1'b1;
          wb_addr_d  = mv_up_q ? (mv_src_q - AW'(1)) : (mv_src_q + AW'(1));
          mv_src_d   = mv_up_q ? (mv_src_q + AW'(1)) : (mv_src_q - AW'(1));
          mv_left_d  = mv_left_q - CW'(1);
        end else if (!wb_valid_q) begin
          state_d = is_insert ? plist_pkg::S_PUT : plist_pkg::S_FINISH;
        end
      end

      plist_pkg::S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = put_idx_q;
        ram_wdata = val_q;
        len_d     = len_q + CW'(1);
        state_d   = plist_pkg::S_FINISH;
      end

      plist_pkg::S_FINISH: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d  = 1'b1;
          m_status_d = status_q;
          m_found_d  = found_q;
          m_count_d  = len_ext[plist_pkg::COUNT_W-1:0];
          state_d    = plist_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = plist_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= plist_pkg::S_IDLE;
      len_q      <= '0;
      wb_valid_q <= 1'b0;
      sc_chk_q   <= 1'b0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      len_q      <= len_d;
      wb_valid_q <= wb_valid_d;
      sc_chk_q   <= sc_chk_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    status_q   <= status_d;
    val_q      <= val_d;
    found_q    <= found_d;
    put_idx_q  <= put_idx_d;
    mv_src_q   <= mv_src_d;
    mv_left_q  <= mv_left_d;
    mv_up_q    <= mv_up_d;
    wb_addr_q  <= wb_addr_d;
    sc_rd_q    <= sc_rd_d;
    sc_idx_q   <= sc_idx_d;
    m_status_q <= m_status_d;
    m_found_q  <= m_found_d;
    m_count_q  <= m_count_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'd0, m_count_q, m_found_q, m_status_q};

endmodule

// File: hw/rtl/plist_ram.sv
// ----------------------------------------------------------------------------
// plist_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module plist_ram #(
  parameter int Width = 32,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: tb/positional_list_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Self-checking bench for the positional list engine. Requests go in on the
// slave stream and are mirrored in a software copy of the list. The copy
// predicts status, found flag and count for each request, and every word on
// the master stream is checked in order against those predictions. Both
// streams stall at random so that gaps hit every phase of the engine.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
  import plist_pkg::*;

  typedef struct packed {
    status_e            status;
    logic               found;
    logic [COUNT_W-1:0] count;
  } reply_t;

  logic                   clk;
  logic                   rst_n;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata;
  logic                   m_tvalid;
  logic                   m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;

  logic [DATA_W-1:0] list_mem [CAPACITY];
  int                list_len;
  reply_t            pending_replies [$];
  int                error_count;
  bit                idle_off;
  int                stall_left;

  positional_list_engine dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("positional_list_engine_tb: done, errors");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void drop_entry(int idx);
    for (int i = idx; i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
    list_len--;
  endfunction

  function automatic reply_t list_apply(op_e op, logic [POS_W-1:0] pos,
                                        logic [DATA_W-1:0] val);
    reply_t rep;
    int     p;
    int     idx;
    rep.status = STS_OK;
    rep.found  = 1'b0;
    p = pos;
    case (op)
      OP_INS_HEAD, OP_INS_TAIL, OP_INS_AT: begin
        idx = (op == OP_INS_HEAD) ? 0 : (op == OP_INS_TAIL) ? list_len : p - 1;
        if (op == OP_INS_AT && (p == 0 || p > list_len + 1)) begin
          rep.status = STS_BADPOS;
        end else if (list_len >= CAPACITY) begin
          rep.status = STS_FULL;
        end else begin
          for (int i = list_len; i > idx; i--) list_mem[i] = list_mem[i - 1];
          list_mem[idx] = val;
          list_len++;
        end
      end
      OP_RM_HEAD, OP_RM_TAIL, OP_RM_AT: begin
        idx = (op == OP_RM_HEAD) ? 0 : (op == OP_RM_TAIL) ? list_len - 1 : p - 1;
        if (list_len == 0) begin
          rep.status = STS_EMPTY;
        end else if (op == OP_RM_AT && (p == 0 || p > list_len)) begin
          rep.status = STS_BADPOS;
        end else begin
          drop_entry(idx);
        end
      end
      default: begin
        idx = -1;
        for (int i = list_len - 1; i >= 0; i--) if (list_mem[i] == val) idx = i;
        if (idx < 0) begin
          rep.status = STS_NOTFOUND;
        end else begin
          rep.found = 1'b1;
          if (op == OP_RM_VAL) drop_entry(idx);
        end
      end
    endcase
    rep.count = list_len[COUNT_W-1:0];
    return rep;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_request(op_e op, int pos, logic [DATA_W-1:0] val);
    int     gap;
    reply_t rep;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  = {val, pos[POS_W-1:0], op};
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    rep = list_apply(op, pos[POS_W-1:0], val);
    pending_replies.push_back(rep);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : check_reply
    reply_t exp_rep;
    if (rst_n && m_tvalid && m_tready) begin
      if (pending_replies.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
        error_count++;
      end else begin
        exp_rep = pending_replies.pop_front();
        if (m_tdata[2:0] !== exp_rep.status) begin
          $display("%0t: status mismatch, expected %0d, actual %0d", $time,
                   exp_rep.status, m_tdata[2:0]);
          error_count++;
        end
        if (m_tdata[3] !== exp_rep.found) begin
          $display("%0t: found mismatch, expected %0d, actual %0d", $time,
                   exp_rep.found, m_tdata[3]);
          error_count++;
        end
        if (m_tdata[8:4] !== exp_rep.count) begin
          $display("%0t: count mismatch, expected %0d, actual %0d", $time,
                   exp_rep.count, m_tdata[8:4]);
          error_count++;
        end
      end
    end
  end

  initial begin
    m_tready   = 1'b0;
    stall_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready = 1'b0;
        stall_left--;
      end else begin
        m_tready = 1'b1;
        if (!idle_off && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  task automatic test_empty_list();
    send_request(OP_RM_HEAD, 0, 32'h0);
    send_request(OP_RM_TAIL, 0, 32'h0);
    send_request(OP_RM_AT, 1, 32'h0);
    send_request(OP_RM_AT, 0, 32'h0);
    send_request(OP_RM_VAL, 0, 32'h0);
    send_request(OP_SEARCH, 0, 32'h0);
    send_request(OP_INS_AT, 0, 32'h1);
    send_request(OP_INS_AT, 2, 32'h1);
    send_request(OP_INS_AT, 1, 32'h8000_0000);
    send_request(OP_RM_AT, 1, 32'h0);
  endtask

  task automatic test_short_list();
    send_request(OP_INS_TAIL, 31, 32'h7FFF_FFFF);
    send_request(OP_INS_HEAD, 31, 32'hFFFF_FFFF);
    send_request(OP_INS_AT, 3, 32'h0);
    send_request(OP_INS_AT, 2, 32'h5);
    send_request(OP_SEARCH, 0, 32'h7FFF_FFFF);
    send_request(OP_SEARCH, 0, 32'h0001_2345);
    send_request(OP_INS_TAIL, 0, 32'hFFFF_FFFF);
    send_request(OP_RM_VAL, 0, 32'hFFFF_FFFF);
    send_request(OP_RM_VAL, 0, 32'h0001_2345);
    send_request(OP_RM_AT, 5, 32'h0);
    send_request(OP_RM_AT, 4, 32'h0);
    send_request(OP_RM_TAIL, 0, 32'h0);
    send_request(OP_RM_HEAD, 0, 32'h0);
    send_request(OP_RM_AT, 1, 32'h0);
  endtask

  task automatic test_full_list();
    while (list_len < CAPACITY) send_request(OP_INS_TAIL, 0, $urandom());
    send_request(OP_INS_HEAD, 0, 32'h1);
    send_request(OP_INS_TAIL, 0, 32'h1);
    send_request(OP_INS_AT, CAPACITY + 1, 32'h1);
    send_request(OP_INS_AT, CAPACITY + 2, 32'h1);
    send_request(OP_INS_AT, 1, 32'h1);
    send_request(OP_SEARCH, 0, list_mem[CAPACITY-1]);
    send_request(OP_RM_AT, CAPACITY, 32'h0);
    send_request(OP_RM_AT, CAPACITY, 32'h0);
    while (list_len > 0) begin
      if ($urandom_range(0, 1) == 0) send_request(OP_RM_HEAD, 0, 32'h0);
      else send_request(OP_RM_AT, $urandom_range(1, list_len), 32'h0);
    end
    send_request(OP_RM_TAIL, 0, 32'h0);
  endtask

  task automatic test_random_mix(int n, int grow_pct);
    op_e               op;
    int                pos;
    int                limit;
    int                r;
    logic [DATA_W-1:0] val;
    repeat (n) begin
      if ($urandom_range(0, 99) < grow_pct) begin
        case ($urandom_range(0, 2))
          0:       op = OP_INS_HEAD;
          1:       op = OP_INS_TAIL;
          default: op = OP_INS_AT;
        endcase
      end else begin
        case ($urandom_range(0, 4))
          0:       op = OP_RM_HEAD;
          1:       op = OP_RM_TAIL;
          2:       op = OP_RM_AT;
          3:       op = OP_RM_VAL;
          default: op = OP_SEARCH;
        endcase
      end
      limit = (op == OP_INS_AT) ? list_len + 1 : list_len;
      r = $urandom_range(0, 99);
      if (r < 70) pos = $urandom_range(1, (limit > 0) ? limit : 1);
      else if (r < 85) pos = limit + $urandom_range(0, 2);
      else if (r < 90) pos = 0;
      else pos = $urandom_range(0, 31);
      r = $urandom_range(0, 99);
      if (r < 45 && list_len > 0) begin
        val = list_mem[$urandom_range(0, list_len - 1)];
      end else if (r < 70) begin
        val = $urandom_range(0, 7);
        val = val - 32'd4;
      end else if (r < 80) begin
        case ($urandom_range(0, 3))
          0:       val = 32'h8000_0000;
          1:       val = 32'h7FFF_FFFF;
          2:       val = 32'h0000_0000;
          default: val = 32'hFFFF_FFFF;
        endcase
      end else begin
        val = $urandom();
      end
      send_request(op, pos, val);
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    error_count = 0;
    list_len    = 0;
    idle_off    = 1'b0;
    for (int i = 0; i < CAPACITY; i++) list_mem[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_empty_list();
    test_short_list();
    test_full_list();
    for (int round = 0; round < 4; round++) begin
      idle_off = (round == 2);
      test_random_mix(50, 75);
      test_random_mix(50, 25);
    end
    idle_off = 1'b0;
    s_tvalid = 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    repeat (CAPACITY + 10) @(posedge clk);
    if (error_count == 0) begin
      $display("positional_list_engine_tb: done, clean");
    end else begin
      $display("positional_list_engine_tb: done, errors");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/plist_pkg.sv
hw/rtl/plist_ram.sv
hw/rtl/positional_list_engine.sv
tb/positional_list_engine_tb.sv
